### src/lennard_jones_pair_force_top_defines.svh
// Assertion macros for the Lennard-Jones pair force block.
// Used by the port checker; needs clk and rst in the scope of use.
`ifndef LENNARD_JONES_PAIR_FORCE_TOP_DEFINES_SVH
`define LENNARD_JONES_PAIR_FORCE_TOP_DEFINES_SVH

// same-cycle implication
`define LJF_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LJF_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

### src/ljf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the divider step for the LJ pair force block.
// No dependencies.
package ljf_pkg;

  localparam int WORD_W     = 64;
  localparam int DIV_STAGES = 32;
  localparam int DIV_STEPS  = WORD_W / DIV_STAGES;

  localparam logic [63:0] MAX64     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SCALE_LIM = MAX64 / 64'd24;
  localparam logic [63:0] POS_LIM   = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIM   = 64'h0000_8000_0000_0000;

  localparam logic [1:0] REG_WELL_DEPTH = 2'd0;
  localparam logic [1:0] REG_SIGMA      = 2'd1;
  localparam logic [1:0] REG_CUTOFF     = 2'd2;

  localparam logic [31:0] RST_WELL_DEPTH = 32'd65536;
  localparam logic [31:0] RST_SIGMA      = 32'd65536;
  localparam logic [31:0] RST_CUTOFF     = 32'd196608;

  // data that rides along the arithmetic units
  typedef struct packed {
    logic             valid;
    logic [2:0][31:0] m;
    logic [2:0]       neg;
    logic             in_range;
    logic             coinc;
    logic             ovf;
    logic             s_neg;
    logic [63:0]      r2;
    logic [63:0]      q;
    logic [63:0]      q3;
  } side_t;

  // one restoring step: returns {quotient bit, new remainder}; rem < d
  function automatic logic [64:0] div_step(logic [63:0] rem, logic [63:0] d,
                                           logic nb);
    logic [64:0] t;
    logic [64:0] diff;
    t    = {rem, nb};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) return {1'b1, diff[63:0]};
    else return {1'b0, t[63:0]};
  endfunction

endpackage

### src/ljf_mulq.sv
`timescale 1ns / 1ps
// Three-stage saturating Q32.32 multiplier, y = floor(a*b / 2^32).
// Depends on ljf_pkg.
module ljf_mulq (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  ljf_pkg::side_t  side_i,
  input  logic [63:0]     a,
  input  logic [63:0]     b,
  output logic [63:0]     y,
  output logic            ovf,
  output ljf_pkg::side_t  side_o
);

  ljf_pkg::side_t s1, s2, s3;
  logic [63:0] hh, hl, lh, ll;
  logic [63:0] hh2;
  logic [64:0] mid;
  logic [31:0] lohi;
  logic [96:0] total;
  logic [63:0] yr;
  logic        ovr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
    end else if (en) begin
      s1 <= side_i;
      s2 <= s1;
      s3 <= s2;
    end
  end

  // partial products, then the cross sum, then the final add
  always_ff @(posedge clk) begin
    if (en) begin
      hh   <= a[63:32] * b[63:32];
      hl   <= a[63:32] * b[31:0];
      lh   <= a[31:0] * b[63:32];
      ll   <= a[31:0] * b[31:0];
      hh2  <= hh;
      mid  <= {1'b0, hl} + {1'b0, lh};
      lohi <= ll[63:32];
      ovr  <= |total[96:64];
      yr   <= total[63:0];
    end
  end

  assign total  = {1'b0, hh2, 32'b0} + {32'b0, mid} + {65'b0, lohi};
  assign y      = ovr ? ljf_pkg::MAX64 : yr;
  assign ovf    = ovr;
  assign side_o = s3;

endmodule

### src/ljf_divq.sv
`timescale 1ns / 1ps
// Pipelined saturating Q32.32 divider, y = floor(n * 2^32 / d).
// Two quotient bits per stage; depends on ljf_pkg.
module ljf_divq (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  ljf_pkg::side_t  side_i,
  input  logic [63:0]     n,
  input  logic [63:0]     d,
  output logic [63:0]     y,
  output logic            ovf,
  output ljf_pkg::side_t  side_o
);

  localparam int NST = ljf_pkg::DIV_STAGES;

  logic [63:0]    rem   [NST];
  logic [63:0]    quo   [NST];
  logic [63:0]    dvd   [NST];
  logic [63:0]    dd    [NST];
  logic           ov    [NST];
  ljf_pkg::side_t sd    [NST];

  logic [63:0]    rem_i [NST];
  logic [63:0]    quo_i [NST];
  logic [63:0]    dvd_i [NST];
  logic [63:0]    dd_i  [NST];
  logic           ov_i  [NST];
  ljf_pkg::side_t sd_i  [NST];

  for (genvar i = 0; i < NST; i++) begin : g_stage
    logic [63:0] rem_n, quo_n, dvd_n;

    if (i == 0) begin : g_first
      // quotient below 2^64 exactly when the high half of n is below d
      assign rem_i[i] = {32'b0, n[63:32]};
      assign quo_i[i] = 64'b0;
      assign dvd_i[i] = {n[31:0], 32'b0};
      assign dd_i[i]  = d;
      assign ov_i[i]  = (d[63:32] == 32'b0) && (n[63:32] >= d[31:0]);
      assign sd_i[i]  = side_i;
    end else begin : g_next
      assign rem_i[i] = rem[i-1];
      assign quo_i[i] = quo[i-1];
      assign dvd_i[i] = dvd[i-1];
      assign dd_i[i]  = dd[i-1];
      assign ov_i[i]  = ov[i-1];
      assign sd_i[i]  = sd[i-1];
    end

    always_comb begin
      logic [64:0] r;
      rem_n = rem_i[i];
      quo_n = quo_i[i];
      dvd_n = dvd_i[i];
      for (int j = 0; j < ljf_pkg::DIV_STEPS; j++) begin
        r     = ljf_pkg::div_step(rem_n, dd_i[i], dvd_n[63]);
        rem_n = r[63:0];
        quo_n = {quo_n[62:0], r[64]};
        dvd_n = {dvd_n[62:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[i].valid <= 1'b0;
      end else if (en) begin
        sd[i] <= sd_i[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= rem_n;
        quo[i] <= quo_n;
        dvd[i] <= dvd_n;
        dd[i]  <= dd_i[i];
        ov[i]  <= ov_i[i];
      end
    end
  end

  assign y      = ov[NST-1] ? ljf_pkg::MAX64 : quo[NST-1];
  assign ovf    = ov[NST-1];
  assign side_o = sd[NST-1];

endmodule

### src/lennard_jones_pair_force_top.sv
`timescale 1ns / 1ps
// Lennard-Jones 12-6 pair force: one pair in per cycle while in_stall is low; stages:
// front end 3, two 32-stage dividers, four 3-stage multipliers, 4 more.
// The two quotients, r^2 into sigma^2 and into the scaled term, set depth.
// rst (sync, high) clears all valid bits and loads default eps/sigma/cutoff.
// Depends on ljf_pkg, ljf_mulq, ljf_divq.
module lennard_jones_pair_force_top (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // displacement in
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] dx,
  input  logic signed [31:0] dy,
  input  logic signed [31:0] dz,
  // force out
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] fx,
  output logic signed [47:0] fy,
  output logic signed [47:0] fz,
  output logic               in_range,
  output logic               coincident,
  output logic               clipped
);

  // Whole pipe moves as one: it holds only while the output has a result
  // that is not taken. No bubbles are squeezed, none are needed at 1/cycle.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------- configuration ----------------
  logic [31:0] well_depth, sigma, cutoff;
  logic [63:0] c2, s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      well_depth <= ljf_pkg::RST_WELL_DEPTH;
      sigma      <= ljf_pkg::RST_SIGMA;
      cutoff     <= ljf_pkg::RST_CUTOFF;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ljf_pkg::REG_WELL_DEPTH: well_depth <= cfg_data;
        ljf_pkg::REG_SIGMA:      sigma      <= cfg_data;
        ljf_pkg::REG_CUTOFF:     cutoff     <= cfg_data;
        default: ;
      endcase
    end
  end

  // squared constants, refreshed every cycle (the user keeps config static while busy; the block does not enforce it)
  always_ff @(posedge clk) begin
    c2 <= cutoff * cutoff;
    s2 <= sigma * sigma;
  end

  // ---------------- front end: magnitudes, squares, r^2 ----------------
  ljf_pkg::side_t st1, st2, st3, st1_n, st3_n;
  logic [2:0][63:0] sq;
  logic [63:0]      r2_n;

  always_comb begin
    st1_n       = '0;
    st1_n.valid = in_valid;
    st1_n.neg   = {dz[31], dy[31], dx[31]};
    st1_n.m[0]  = dx[31] ? (32'd0 - dx) : dx;
    st1_n.m[1]  = dy[31] ? (32'd0 - dy) : dy;
    st1_n.m[2]  = dz[31] ? (32'd0 - dz) : dz;
  end

  assign r2_n = sq[0] + sq[1] + sq[2];   // at most 3 * 2^62, no carry out

  always_comb begin
    st3_n          = st2;
    st3_n.r2       = r2_n;
    st3_n.in_range = (r2_n <= c2);
    st3_n.coinc    = (r2_n == 64'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1.valid <= 1'b0;
      st2.valid <= 1'b0;
      st3.valid <= 1'b0;
    end else if (en) begin
      st1 <= st1_n;
      st2 <= st1;
      st3 <= st3_n;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq[i] <= st1.m[i] * st1.m[i];
    end
  end

  // ---------------- q = sigma^2 / r^2 ----------------
  ljf_pkg::side_t d1_o, m1_i, m1_o, m2_o, m3_i, m3_o;
  logic [63:0] q, q2, q3, q6;
  logic        q_ovf, q2_ovf, q3_ovf, q6_ovf;

  ljf_divq u_div_q (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .side_i (st3),
    .n      (s2),
    .d      (st3.r2),
    .y      (q),
    .ovf    (q_ovf),
    .side_o (d1_o)
  );

  always_comb begin
    m1_i     = d1_o;
    m1_i.q   = q;
    m1_i.ovf = q_ovf;
  end

  // ---------------- powers of q ----------------
  ljf_mulq u_mul_q2 (
    .clk(clk), .rst(rst), .en(en), .side_i(m1_i), .a(q), .b(q),
    .y(q2), .ovf(q2_ovf), .side_o(m1_o)
  );

  ljf_pkg::side_t m2_i;
  always_comb begin
    m2_i     = m1_o;
    m2_i.ovf = m1_o.ovf | q2_ovf;
  end

  ljf_mulq u_mul_q3 (
    .clk(clk), .rst(rst), .en(en), .side_i(m2_i), .a(q2), .b(m1_o.q),
    .y(q3), .ovf(q3_ovf), .side_o(m2_o)
  );

  always_comb begin
    m3_i     = m2_o;
    m3_i.q3  = q3;
    m3_i.ovf = m2_o.ovf | q3_ovf;
  end

  ljf_mulq u_mul_q6 (
    .clk(clk), .rst(rst), .en(en), .side_i(m3_i), .a(q3), .b(q3),
    .y(q6), .ovf(q6_ovf), .side_o(m3_o)
  );

  // ---------------- term = |2 q^6 - q^3| ----------------
  ljf_pkg::side_t tt, tt_n;
  logic [63:0] term, term_n;
  logic [64:0] q6x2;

  assign q6x2 = {q6, 1'b0};

  always_comb begin
    tt_n     = m3_o;
    tt_n.ovf = m3_o.ovf | q6_ovf | q6x2[64];
    if (tt_n.ovf) begin
      term_n = ljf_pkg::MAX64;       // saturated powers count as repulsive
    end else if (q6x2[63:0] >= m3_o.q3) begin
      term_n = q6x2[63:0] - m3_o.q3;
    end else begin
      term_n     = m3_o.q3 - q6x2[63:0];
      tt_n.s_neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tt.valid <= 1'b0;
    end else if (en) begin
      tt <= tt_n;
    end
  end

  always_ff @(posedge clk) begin
    if (en) term <= term_n;
  end

  // ---------------- a = term * eps, b = a / r^2 ----------------
  ljf_pkg::side_t m4_o, d2_i, d2_o;
  logic [63:0] av, bv;
  logic        a_ovf, b_ovf;

  ljf_mulq u_mul_eps (
    .clk(clk), .rst(rst), .en(en), .side_i(tt), .a(term),
    .b({16'b0, well_depth, 16'b0}),
    .y(av), .ovf(a_ovf), .side_o(m4_o)
  );

  always_comb begin
    d2_i     = m4_o;
    d2_i.ovf = m4_o.ovf | a_ovf;
  end

  ljf_divq u_div_r2 (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .side_i (d2_i),
    .n      (av),
    .d      (m4_o.r2),
    .y      (bv),
    .ovf    (b_ovf),
    .side_o (d2_o)
  );

  // ---------------- s = 24 b ----------------
  ljf_pkg::side_t ss, ss_n;
  logic [63:0] sv, sv_n;

  always_comb begin
    ss_n = d2_o;
    if (well_depth == 32'd0) begin
      // zero well depth: force vanishes, overflow forgotten
      ss_n.ovf = 1'b0;
      sv_n     = 64'd0;
    end else if (d2_o.ovf || b_ovf || (bv > ljf_pkg::SCALE_LIM)) begin
      ss_n.ovf = 1'b1;
      sv_n     = ljf_pkg::MAX64;
    end else begin
      ss_n.ovf = 1'b0;
      sv_n     = {bv[59:0], 4'b0} + {bv[60:0], 3'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ss.valid <= 1'b0;
    end else if (en) begin
      ss <= ss_n;
      sv <= sv_n;
    end
  end

  // ---------------- per-component products ----------------
  ljf_pkg::side_t pp;
  logic [2:0][63:0] ph, pl;
  logic             s_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      pp.valid <= 1'b0;
    end else if (en) begin
      pp     <= ss;
      s_zero <= (sv == 64'd0);
      for (int i = 0; i < 3; i++) begin
        ph[i] <= sv[63:32] * ss.m[i];
        pl[i] <= sv[31:0] * ss.m[i];
      end
    end
  end

  // ---------------- scale, sign, clamp ----------------
  logic [2:0][47:0] f_n;
  logic [2:0]       clip_n;

  always_comb begin
    logic [63:0] mag, lim;
    logic        neg;
    for (int i = 0; i < 3; i++) begin
      neg       = pp.s_neg ^ pp.neg[i];
      lim       = neg ? ljf_pkg::NEG_LIM : ljf_pkg::POS_LIM;
      mag       = {1'b0, ph[i][54:0], 8'b0} + {24'b0, pl[i][63:24]};
      f_n[i]    = 48'd0;
      clip_n[i] = 1'b0;
      if (pp.in_range && !pp.coinc && !s_zero && (pp.m[i] != 32'd0)) begin
        if (pp.ovf || (|ph[i][63:55]) || (mag > lim)) begin
          clip_n[i] = 1'b1;
          mag       = lim;
        end
        f_n[i] = neg ? (48'd0 - mag[47:0]) : mag[47:0];
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= pp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx         <= f_n[0];
      fy         <= f_n[1];
      fz         <= f_n[2];
      in_range   <= pp.in_range;
      coincident <= pp.in_range && pp.coinc;
      clipped    <= |clip_n;
    end
  end

endmodule

### src/ljf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for lennard_jones_pair_force_top, bound to the top.
// Depends on lennard_jones_pair_force_top_defines.svh.
`include "lennard_jones_pair_force_top_defines.svh"
module ljf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [47:0] fx,
  input logic signed [47:0] fy,
  input logic signed [47:0] fz,
  input logic               in_range,
  input logic               coincident,
  input logic               clipped
);

  `LJF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(fx) && $stable(fy) && $stable(fz) && $stable(clipped), "stalled result changed")
  `LJF_ASSERT_NOW(a_stall_path, 1'b1, in_stall == (out_valid && out_stall), "input stall not tied to held output")
  `LJF_ASSERT_NOW(a_coinc_zero, out_valid && coincident, in_range && !clipped && fx == 48'sd0 && fy == 48'sd0 && fz == 48'sd0, "coincident pair with force")
  `LJF_ASSERT_NOW(a_cut_zero, out_valid && !in_range, !coincident && !clipped && fx == 48'sd0 && fy == 48'sd0 && fz == 48'sd0, "pair beyond cutoff with force")

endmodule

bind lennard_jones_pair_force_top ljf_checker u_ljf_checker (.*);

### tb/lennard_jones_pair_force_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lennard_jones_pair_force_top: a bit-exact force
// predictor feeds a scoreboard class; randomized idle on both channels.
// Depends on ljf_pkg and the block itself.
module lennard_jones_pair_force_top_tb;

  localparam int IDLE_MAX  = 18;
  localparam int DOG_LIMIT = 20000;
  localparam int LATENCY   = 83;

  typedef struct {
    logic [47:0] fx, fy, fz;
    logic        in_range, coincident, clipped;
  } force_t;

  // expected forces, oldest first
  class force_board;
    force_t pending[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    function void note_pair(force_t f);
      pending.insert(pending.size(), f);
    endfunction

    function void check_force(force_t got);
      force_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected transfer fx=%h", $realtime, got.fx);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.fx !== want.fx) begin
        $display("%0t: fx exp %h got %h", $realtime, want.fx, got.fx);
        errors++;
      end
      if (got.fy !== want.fy) begin
        $display("%0t: fy exp %h got %h", $realtime, want.fy, got.fy);
        errors++;
      end
      if (got.fz !== want.fz) begin
        $display("%0t: fz exp %h got %h", $realtime, want.fz, got.fz);
        errors++;
      end
      if (got.in_range !== want.in_range) begin
        $display("%0t: in_range exp %b got %b", $realtime, want.in_range, got.in_range);
        errors++;
      end
      if (got.coincident !== want.coincident) begin
        $display("%0t: coincident exp %b got %b", $realtime, want.coincident,
                 got.coincident);
        errors++;
      end
      if (got.clipped !== want.clipped) begin
        $display("%0t: clipped exp %b got %b", $realtime, want.clipped, got.clipped);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid, in_stall;
  logic signed [31:0] dx, dy, dz;
  logic               out_valid, out_stall;
  logic signed [47:0] fx, fy, fz;
  logic               in_range, coincident, clipped;

  lennard_jones_pair_force_top u_dut (.*);

  force_board board;
  // predictor's copy of the registers
  logic [31:0] eps_q, sigma_q, cutoff_q;
  int          dog;
  int          out_idle_max;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---- fixed point helpers; sat_add, qmul and qdiv saturate at 2^64-1 ----
  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, ref bit ovf);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64]) begin
      ovf = 1;
      return ljf_pkg::MAX64;
    end
    return s[63:0];
  endfunction

  // floor(a*b / 2^32); the full 128-bit product is exact
  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b, ref bit ovf);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:96] != 0) begin
      ovf = 1;
      return ljf_pkg::MAX64;
    end
    return p[95:32];
  endfunction

  // floor(n*2^32 / d), d nonzero
  function automatic logic [63:0] qdiv(logic [63:0] n, logic [63:0] d, ref bit ovf);
    logic [95:0] r;
    r = {n, 32'd0} / {32'd0, d};
    if (r[95:64] != 0) begin
      ovf = 1;
      return ljf_pkg::MAX64;
    end
    return r[63:0];
  endfunction

  function automatic logic [47:0] one_component(logic [63:0] s, bit s_neg, bit ovf,
                                                logic [31:0] m, bit d_neg, ref bit clip);
    bit          neg;
    logic [63:0] mag, lim;
    logic [95:0] p;
    neg = s_neg ^ d_neg;
    if (m == 0 || s == 0) return 48'd0;
    lim = neg ? ljf_pkg::NEG_LIM : ljf_pkg::POS_LIM;
    if (ovf) mag = lim + 1;
    else begin
      p = ({32'd0, s} * {64'd0, m}) >> 24;
      mag = (p[95:64] != 0) ? ljf_pkg::MAX64 : p[63:0];
    end
    if (mag > lim) begin
      clip = 1;
      mag = lim;
    end
    return neg ? (48'd0 - mag[47:0]) : mag[47:0];
  endfunction

  function automatic force_t predict_force(logic [31:0] ix, logic [31:0] iy,
                                           logic [31:0] iz);
    force_t      f;
    logic [31:0] m[3];
    bit          ng[3];
    logic [31:0] raw[3];
    logic [63:0] r2, c2, s2, q, q2, q3, q6, q6x2, term, epsq, a, b, s;
    bit          ovf, clip, s_neg;
    ovf = 0;
    clip = 0;
    s_neg = 0;
    raw[0] = ix;
    raw[1] = iy;
    raw[2] = iz;
    for (int i = 0; i < 3; i++) begin
      ng[i] = raw[i][31];
      m[i] = ng[i] ? (32'd0 - raw[i]) : raw[i];  // -2^31 magnitude wraps to 2^31
    end
    r2 = 64'(m[0]) * m[0] + 64'(m[1]) * m[1] + 64'(m[2]) * m[2];
    c2 = 64'(cutoff_q) * cutoff_q;
    s2 = 64'(sigma_q) * sigma_q;
    f = '{48'd0, 48'd0, 48'd0, 1'b0, 1'b0, 1'b0};
    if (r2 > c2) return f;
    f.in_range = 1'b1;
    if (r2 == 0) begin
      f.coincident = 1'b1;
      return f;
    end
    q = qdiv(s2, r2, ovf);
    q2 = qmul(q, q, ovf);
    q3 = qmul(q2, q, ovf);
    q6 = qmul(q3, q3, ovf);
    q6x2 = sat_add(q6, q6, ovf);
    if (ovf) term = ljf_pkg::MAX64;
    else if (q6x2 >= q3) term = q6x2 - q3;
    else begin
      term = q3 - q6x2;
      s_neg = 1;
    end
    epsq = {16'd0, eps_q, 16'd0};
    if (epsq == 0) begin
      s = 0;
      ovf = 0;
    end else begin
      a = qmul(term, epsq, ovf);
      b = qdiv(a, r2, ovf);
      if (b > ljf_pkg::SCALE_LIM) begin
        ovf = 1;
        s = ljf_pkg::MAX64;
      end else s = b * 24;
    end
    f.fx = one_component(s, s_neg, ovf, m[0], ng[0], clip);
    f.fy = one_component(s, s_neg, ovf, m[1], ng[1], clip);
    f.fz = one_component(s, s_neg, ovf, m[2], ng[2], clip);
    f.clipped = clip;
    return f;
  endfunction

  // ---- drivers ----
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      ljf_pkg::REG_WELL_DEPTH: eps_q    = val;
      ljf_pkg::REG_SIGMA:      sigma_q  = val;
      default:                 cutoff_q = val;
    endcase
    @(posedge clk);
  endtask

  // one pair: random idle first, then hold valid until the transfer;
  // valid stays up for a following pair, drain or the next idle drops it
  task automatic send_pair(logic [31:0] ix, logic [31:0] iy, logic [31:0] iz, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    dx <= ix;
    dy <= iy;
    dz <= iz;
    do @(posedge clk); while (in_stall);
    board.note_pair(predict_force(ix, iy, iz));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // small vectors in modes 1 to 3, the full 32-bit range in mode 0; random sign
  function automatic logic [31:0] rand_coord(int mode);
    logic [31:0] v;
    case (mode)
      0: v = $urandom;
      1: v = $urandom_range(0, 32'h0004_0000);
      2: v = $urandom_range(0, 32'h0000_4000);
      default: v = $urandom_range(0, 32'h0000_0100);
    endcase
    if ($urandom_range(0, 1)) v = 32'd0 - v;
    return v;
  endfunction

  task automatic random_phase(int n, int gmax);
    int mode;
    for (int k = 0; k < n; k++) begin
      mode = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      send_pair(rand_coord(mode), rand_coord(mode),
                ($urandom_range(0, 7) == 0) ? 32'd0 : rand_coord(mode),
                $urandom_range(0, gmax));
    end
  endtask

  // receiver: random stall drawn per result, sometimes no stall at all
  initial begin
    int w;
    out_stall = 1'b1;
    @(posedge clk iff !rst);
    forever begin
      w = $urandom_range(0, out_idle_max);
      if (w != 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      board.check_force('{fx, fy, fz, in_range, coincident, clipped});
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) dog <= 0;
    else dog <= dog + 1;
    if (dog >= DOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    board = new();
    out_idle_max = IDLE_MAX;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = ljf_pkg::REG_WELL_DEPTH;
    cfg_data = '0;
    in_valid = 1'b0;
    dx = '0;
    dy = '0;
    dz = '0;
    dog = 0;
    eps_q = ljf_pkg::RST_WELL_DEPTH;
    sigma_q = ljf_pkg::RST_SIGMA;
    cutoff_q = ljf_pkg::RST_CUTOFF;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults, then extremes of the fields
    send_pair(32'd0, 32'd0, 32'd0, 0);                  // coincident
    send_pair(32'h0001_0000, 32'd0, 32'd0, 0);          // r = sigma
    send_pair(32'h0001_1F5C, 32'd0, 32'd0, 1);          // near minimum
    send_pair(32'hFFFF_0000, 32'h0000_8000, 32'd0, 0);
    send_pair(32'h0003_0000, 32'd0, 32'd0, 0);          // at cutoff
    send_pair(32'h0003_0001, 32'd0, 32'd0, 0);          // just beyond
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_pair(32'd1, 32'd0, 32'd0, 0);                  // scalar overflow
    send_pair(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 2);
    send_pair(32'h0000_4000, 32'hFFFF_C000, 32'd0, 0);  // clipped
    send_pair(32'h0001_8000, 32'h0000_8000, 32'h0000_8000, 0);
    drain();

    // wide cutoff so large vectors reach the arithmetic
    write_reg(ljf_pkg::REG_CUTOFF, 32'hFFFF_FFFF);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_pair(32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 0);
    send_pair(32'h0100_0000, 32'd0, 32'd0, 0);
    drain();
    write_reg(ljf_pkg::REG_WELL_DEPTH, 32'd0);          // zero well depth
    send_pair(32'd1, 32'd1, 32'd0, 0);
    send_pair(32'h0001_0000, 32'd0, 32'd0, 0);
    drain();
    write_reg(ljf_pkg::REG_WELL_DEPTH, 32'hFFFF_FFFF);
    write_reg(ljf_pkg::REG_SIGMA, 32'd0);               // zero sigma
    send_pair(32'h0000_8000, 32'd0, 32'd0, 0);
    drain();
    write_reg(ljf_pkg::REG_SIGMA, 32'hFFFF_FFFF);
    write_reg(ljf_pkg::REG_CUTOFF, 32'd0);
    send_pair(32'd0, 32'd0, 32'd0, 0);
    send_pair(32'd1, 32'd0, 32'd0, 0);
    drain();

    // random phases over several settings; phase 1 runs with no idle on either channel
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(ljf_pkg::REG_WELL_DEPTH, ljf_pkg::RST_WELL_DEPTH);
          write_reg(ljf_pkg::REG_SIGMA, ljf_pkg::RST_SIGMA);
          write_reg(ljf_pkg::REG_CUTOFF, ljf_pkg::RST_CUTOFF);
        end
        1: out_idle_max = 0;
        2: begin
          out_idle_max = IDLE_MAX;
          write_reg(ljf_pkg::REG_WELL_DEPTH, $urandom);
          write_reg(ljf_pkg::REG_SIGMA, $urandom_range(0, 32'h0004_0000));
          write_reg(ljf_pkg::REG_CUTOFF, $urandom);
        end
        3: write_reg(ljf_pkg::REG_WELL_DEPTH, 32'hFFFF_FFFF);
        4: begin
          write_reg(ljf_pkg::REG_WELL_DEPTH, $urandom_range(1, 32'h0000_0100));
          write_reg(ljf_pkg::REG_SIGMA, $urandom_range(0, 32'h0000_4000));
          write_reg(ljf_pkg::REG_CUTOFF, $urandom_range(0, 32'h0004_0000));
        end
        5: begin
          write_reg(ljf_pkg::REG_WELL_DEPTH, $urandom);
          write_reg(ljf_pkg::REG_SIGMA, $urandom);
          write_reg(ljf_pkg::REG_CUTOFF, $urandom);
        end
        default: begin
          write_reg(ljf_pkg::REG_WELL_DEPTH, $urandom_range(1, 32'h0010_0000));
          write_reg(ljf_pkg::REG_SIGMA, $urandom_range(32'h0000_8000, 32'h0002_0000));
          write_reg(ljf_pkg::REG_CUTOFF, 32'h0004_0000);
        end
      endcase
      random_phase(100, (ph == 1) ? 0 : IDLE_MAX);
      drain();
    end

    if (board.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
